@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent assertions of the mouse button decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, inactive while reset is applied.
`define MBED_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, inactive while reset is applied.
`define MBED_ASSERT_IMPL(label, cond, prop, msg) \
    `MBED_ASSERT(label, (cond) |-> (prop), msg)

`endif

@@ sv/mbed_pkg.sv @@
// ----------------------------------------------------------------------------
// mbed_pkg
// Types, widths and register codes of the mouse button event decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbed_pkg;

    localparam int unsigned NUM_BUTTONS = 3;
    localparam int unsigned COORD_W     = 16;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned LEVELS_W    = 3;
    localparam int unsigned FLAGS_W     = 12;
    localparam int unsigned RECT_W      = 64;
    localparam int unsigned WIN_W       = 13;
    localparam int unsigned DIM_W       = 15;
    localparam int unsigned CFG_DATA_W  = 15;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [WIN_W-1:0] WIN_RESET    = 13'd500;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 15'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 15'd480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DBL_WINDOW    = 2'd0,
        REG_CLIENT_WIDTH  = 2'd1,
        REG_CLIENT_HEIGHT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [WIN_W-1:0] dbl_window;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cursor_x;
        logic signed [COORD_W-1:0] cursor_y;
        logic [LEVELS_W-1:0]       button_levels;
        logic [TIME_W-1:0]         now_ms;
    } sample_t;

    // Input register contents handed to the evaluation stage.
    typedef struct packed {
        logic    valid;
        sample_t item;
    } stage_t;

endpackage

@@ sv/mbed_sample_if.sv @@
// ----------------------------------------------------------------------------
// mbed_sample_if
// Channel carrying one pointer sample per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbed_sample_if
    import mbed_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] cursor_x;
    logic signed [COORD_W-1:0] cursor_y;
    logic [LEVELS_W-1:0]       button_levels;
    logic [TIME_W-1:0]         now_ms;

    modport source (output valid, cursor_x, cursor_y, button_levels, now_ms, input ready);
    modport sink   (input valid, cursor_x, cursor_y, button_levels, now_ms, output ready);
endinterface

@@ sv/mbed_report_if.sv @@
// ----------------------------------------------------------------------------
// mbed_report_if
// Channel carrying one button event report per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbed_report_if
    import mbed_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FLAGS_W-1:0] event_flags;
    logic               cursor_inside;
    logic [RECT_W-1:0]  left_drag_rect;
    logic [RECT_W-1:0]  middle_drag_rect;
    logic [RECT_W-1:0]  right_drag_rect;

    modport source (output valid, event_flags, cursor_inside, left_drag_rect,
                    middle_drag_rect, right_drag_rect, input ready);
    modport sink   (input valid, event_flags, cursor_inside, left_drag_rect,
                    middle_drag_rect, right_drag_rect, output ready);
endinterface

@@ sv/mbed_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mbed_cfg_regs
// Configuration registers: double click window and client area size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbed_cfg_regs
    import mbed_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dbl_window <= WIN_RESET;
            cfg_reg.width      <= WIDTH_RESET;
            cfg_reg.height     <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_DBL_WINDOW:    cfg_reg.dbl_window <= cfg_wdata[WIN_W-1:0];
                REG_CLIENT_WIDTH:  cfg_reg.width      <= cfg_wdata[DIM_W-1:0];
                REG_CLIENT_HEIGHT: cfg_reg.height     <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/mbed_in_stage.sv @@
// ----------------------------------------------------------------------------
// mbed_in_stage
// Input register: captures one sample and holds it until it is evaluated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbed_in_stage
    import mbed_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mbed_sample_if.sink  sample,
    input  logic         advance,
    output stage_t       stage
);

    logic    valid_reg;
    logic    valid_next;
    sample_t item_reg;
    logic    accept;

    // The register frees up in the same cycle as its contents move on.
    assign sample.ready = !valid_reg || advance;
    assign accept       = sample.valid && sample.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cursor_x      <= sample.cursor_x;
            item_reg.cursor_y      <= sample.cursor_y;
            item_reg.button_levels <= sample.button_levels;
            item_reg.now_ms        <= sample.now_ms;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

@@ sv/mbed_eval.sv @@
// ----------------------------------------------------------------------------
// mbed_eval
// Button state, edge and double click decode, drag rectangles and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbed_eval
    import mbed_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  stage_t        stage,
    output logic          advance,
    mbed_report_if.source report
);

    logic [FLAGS_W-1:0]     held_reg;
    logic [FLAGS_W-1:0]     held_next;
    logic [TIME_W-1:0]      last_rel_reg  [NUM_BUTTONS];
    logic [TIME_W-1:0]      last_rel_next [NUM_BUTTONS];
    logic [RECT_W-1:0]      rect_reg      [NUM_BUTTONS];
    logic [RECT_W-1:0]      rect_next     [NUM_BUTTONS];
    logic [TIME_W-1:0]      limit         [NUM_BUTTONS];
    logic                   in_area;
    logic                   in_area_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [NUM_BUTTONS-1:0] old_down;
    logic [NUM_BUTTONS-1:0] down;
    logic [NUM_BUTTONS-1:0] press;
    logic [NUM_BUTTONS-1:0] rel;
    logic [NUM_BUTTONS-1:0] dbl;
    logic [2*COORD_W-1:0]   point;

    // The state registers double as the result payload, so an item may only
    // move in when the previous result has gone or is leaving now.
    assign advance = stage.valid && (!out_valid_reg || report.ready);

    // Negative coordinates fail on the sign bit; the rest compare unsigned.
    assign in_area = !stage.item.cursor_x[COORD_W-1] && !stage.item.cursor_y[COORD_W-1]
                  && (stage.item.cursor_x[DIM_W-1:0] < cfg.width)
                  && (stage.item.cursor_y[DIM_W-1:0] < cfg.height);

    assign point    = {stage.item.cursor_x, stage.item.cursor_y};
    assign old_down = held_reg[NUM_BUTTONS-1:0];
    assign down     = stage.item.button_levels;
    assign press    = down & ~old_down;
    assign rel      = old_down & ~down;

    always_comb
    begin
        dbl = '0;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            limit[b]         = last_rel_reg[b] + TIME_W'(cfg.dbl_window);
            last_rel_next[b] = last_rel_reg[b];
            rect_next[b]     = rect_reg[b];
            if (rel[b])
            begin
                dbl[b]           = stage.item.now_ms < limit[b];
                last_rel_next[b] = stage.item.now_ms;
            end
            if (down[b])
                rect_next[b][2*COORD_W-1:0] = point;
            if (press[b])
                rect_next[b][RECT_W-1:2*COORD_W] = point;
        end
        held_next = {dbl, rel, press, down};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (report.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                last_rel_reg[b] <= '0;
                rect_reg[b]     <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance && in_area)
            begin
                held_reg <= held_next;
                for (int b = 0; b < NUM_BUTTONS; b++)
                begin
                    last_rel_reg[b] <= last_rel_next[b];
                    rect_reg[b]     <= rect_next[b];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            in_area_reg <= in_area;
    end

    assign report.valid            = out_valid_reg;
    assign report.event_flags      = held_reg;
    assign report.cursor_inside    = in_area_reg;
    assign report.left_drag_rect   = rect_reg[0];
    assign report.middle_drag_rect = rect_reg[1];
    assign report.right_drag_rect  = rect_reg[2];

endmodule

@@ sv/mouse_button_event_decoder.sv @@
// ----------------------------------------------------------------------------
// mouse_button_event_decoder
// Path: a sample's report becomes valid once the input register has handed
// it to the result stage and the result register has captured it.
// Throughput: one sample per cycle while report.ready is high, set by the input
// register and the result stage, which both hand on in the cycle they are emptied.
// Reset: asynchronous, active low; clears button state, release times and
// drag rectangles and loads the default window and client size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mouse_button_event_decoder
    import mbed_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    mbed_sample_if.sink            sample,
    mbed_report_if.source          report
);

    cfg_t   cfg;
    stage_t stage;
    logic   advance;

    mbed_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mbed_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample),
        .advance (advance),
        .stage   (stage)
    );

    mbed_eval u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .stage   (stage),
        .advance (advance),
        .report  (report)
    );

endmodule

@@ sv/mbed_checker.sv @@
// ----------------------------------------------------------------------------
// mbed_checker
// Port-level checks on the reported button flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mbed_checker
    import mbed_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               report_valid,
    input logic               report_ready,
    input logic [FLAGS_W-1:0] event_flags
);

    logic [NUM_BUTTONS-1:0] down;
    logic [NUM_BUTTONS-1:0] press;
    logic [NUM_BUTTONS-1:0] rel;
    logic [NUM_BUTTONS-1:0] dbl;

    assign {dbl, rel, press, down} = event_flags;

    `MBED_ASSERT_IMPL(a_stall_holds, report_valid && !report_ready, ##1 $stable(event_flags), "flags changed during a stalled transaction")
    `MBED_ASSERT_IMPL(a_press_is_down, report_valid, (press & ~down) == '0, "press edge on a button that is not down")
    `MBED_ASSERT_IMPL(a_release_not_down, report_valid, (rel & down) == '0, "release edge on a button that is still down")
    `MBED_ASSERT_IMPL(a_double_is_release, report_valid, (dbl & ~rel) == '0, "double click without a release")

endmodule

bind mouse_button_event_decoder mbed_checker u_mbed_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .report_valid (report.valid),
    .report_ready (report.ready),
    .event_flags  (report.event_flags)
);
